// ----- hdl/bfst_pkg.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop schedule table package
// Shared constants, command codes and status types of the controller and
// datapath.
// ----------------------------------------------------------------------------
package bfst_pkg;

  localparam int unsigned MaxJobsDef     = 64;
  localparam int unsigned MaxMachinesDef = 16;
  localparam int unsigned JobTypesDef    = 256;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned DepW     = 24;
  localparam int unsigned FlowW    = 32;

  localparam logic [ModeW-1:0] ModeLoad   = 3'd0;
  localparam logic [ModeW-1:0] ModeAppend = 3'd1;
  localparam logic [ModeW-1:0] ModeInsert = 3'd2;
  localparam logic [ModeW-1:0] ModeSwap   = 3'd3;
  localparam logic [ModeW-1:0] ModeMove   = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  localparam logic [CfgW-1:0] MachinesReset = 5'd16;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_DECODE,
    CMD_HOLD_RD,
    CMD_HOLD_LATCH,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_FIN,
    CMD_ROW_A,
    CMD_ROW_B,
    CMD_CELL,
    CMD_SUM_INIT,
    CMD_SUM,
    CMD_SPAN_RD,
    CMD_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    logic edit;
    logic hold;
    logic shift_more;
    logic cell_last;
    logic row_last;
    logic sum_done;
  } dp_status_t;

endpackage

// ----- hdl/bfst_dpath.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop datapath
// Holds the job order, departure and processing-time memories, the sequence
// length, the flow sum and the result register, and executes one command a
// cycle.
// ----------------------------------------------------------------------------
module bfst_dpath #(
  parameter int unsigned MAX_JOBS     = bfst_pkg::MaxJobsDef,
  parameter int unsigned MAX_MACHINES = bfst_pkg::MaxMachinesDef,
  parameter int unsigned JOB_TYPES    = bfst_pkg::JobTypesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bfst_pkg::cmd_e                 cmd_i,
  output bfst_pkg::dp_status_t           status_o,
  input  logic [bfst_pkg::InDataW-1:0]   in_data_i,
  input  logic [bfst_pkg::ModeW-1:0]     in_mode_i,
  input  logic [bfst_pkg::CfgW-1:0]      machines_i,
  output logic [bfst_pkg::OutDataW-1:0]  out_data_o
);
  import bfst_pkg::*;

  localparam int unsigned JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned LW = $clog2(MAX_JOBS + 1);
  localparam int unsigned MW = $clog2(MAX_MACHINES);
  localparam int unsigned NW = $clog2(MAX_MACHINES + 1);
  localparam int unsigned TW = $clog2(JOB_TYPES);

  logic [7:0]        f_job;
  logic [3:0]        f_mach;
  logic [9:0]        f_tval;
  logic [5:0]        f_pa;
  logic [6:0]        f_pb;
  logic [31:0]       len32, pa32, pb32, job32, mach32, pos32;

  logic [NW-1:0]     nm;
  logic [MW-1:0]     nm_last;

  logic [LW-1:0]     len_q;
  logic [FlowW-1:0]  flow_q;
  logic              edit_q, hold_q;

  logic [1:0]        st_q;
  logic [7:0]        job_q, t_q, job_r_q;
  logic [LW-1:0]     pa_q, pb_q, i_q, stop_q, fin_q, j_q, k_q;
  logic              dir_q, swap_q, p_q;
  logic [MW-1:0]     m_q;
  logic [DepW-1:0]   acc_q;
  logic [FlowW-1:0]  out_flow_q;
  logic [DepW-1:0]   out_span_q;
  logic [6:0]        out_cnt_q;
  logic [1:0]        out_st_q;

  logic [1:0]        st_c;
  logic              edit_c, hold_c, ld_c, grow_c, dir_c, swap_c;
  logic [LW-1:0]     i_c, stop_c, fin_c, from_c;

  logic [LW-1:0]     src;
  logic [JW-1:0]     jm1, lm1;
  logic [24:0]       cell_sum;
  logic [DepW-1:0]   cell_sat, cell_val;
  logic [32:0]       flow_add;
  logic [FlowW-1:0]  flow_sat;

  logic [7:0]        jo_mem [MAX_JOBS];
  logic [DepW-1:0]   dep_mem [2**(JW+MW)];
  logic [9:0]        pt_mem [2**(TW+MW)];

  logic              jo_we, jo_re, dep_we, dep_re, pt_we, pt_re;
  logic [JW-1:0]     jo_waddr, jo_raddr;
  logic [7:0]        jo_wdata, jo_rdata;
  logic [JW+MW-1:0]  dep_waddr, dep_raddr;
  logic [DepW-1:0]   dep_wdata, dep_rdata;
  logic [TW+MW-1:0]  pt_waddr, pt_raddr;
  logic [9:0]        pt_rdata;

  assign f_job  = in_data_i[7:0];
  assign f_mach = in_data_i[11:8];
  assign f_tval = in_data_i[21:12];
  assign f_pa   = in_data_i[27:22];
  assign f_pb   = in_data_i[34:28];
  assign len32  = 32'(len_q);
  assign pa32   = 32'(f_pa);
  assign pb32   = 32'(f_pb);
  assign job32  = 32'(f_job);
  assign mach32 = 32'(f_mach);
  assign pos32  = (in_mode_i == ModeAppend) ? len32 : pb32;

  always_comb begin
    if (machines_i < CfgW'(2)) begin
      nm = NW'(2);
    end else if (32'(machines_i) > MAX_MACHINES) begin
      nm = NW'(MAX_MACHINES);
    end else begin
      nm = NW'(machines_i);
    end
  end
  assign nm_last = MW'(nm - NW'(1));

  // Decode of one input item against the current sequence length and the table bounds.
  always_comb begin
    st_c   = StOk;
    edit_c = 1'b0;
    hold_c = 1'b0;
    ld_c   = 1'b0;
    grow_c = 1'b0;
    dir_c  = 1'b0;
    swap_c = 1'b0;
    i_c    = '0;
    stop_c = '0;
    fin_c  = '0;
    from_c = '0;
    case (in_mode_i)
      ModeLoad: begin
        if (job32 >= JOB_TYPES || mach32 >= MAX_MACHINES) begin
          st_c = StRange;
        end else begin
          ld_c = 1'b1;
        end
      end
      ModeAppend, ModeInsert: begin
        if (len32 >= MAX_JOBS) begin
          st_c = StFull;
        end else if (pos32 > len32 || job32 >= JOB_TYPES) begin
          st_c = StRange;
        end else begin
          edit_c = 1'b1;
          grow_c = 1'b1;
          dir_c  = 1'b1;
          i_c    = len_q;
          stop_c = LW'(pos32);
          fin_c  = LW'(pos32);
          from_c = LW'(pos32);
        end
      end
      ModeSwap: begin
        if (pa32 >= len32 || pb32 >= len32) begin
          st_c = StRange;
        end else begin
          edit_c = 1'b1;
          hold_c = 1'b1;
          swap_c = 1'b1;
          i_c    = LW'(pa32);
          stop_c = LW'(pa32 + 32'd1);
          fin_c  = LW'(pb32);
          from_c = (pa32 < pb32) ? LW'(pa32) : LW'(pb32);
        end
      end
      ModeMove: begin
        if (pa32 >= len32 || pb32 > len32) begin
          st_c = StRange;
        end else if (pb32 != pa32 && pb32 != pa32 + 32'd1) begin
          edit_c = 1'b1;
          hold_c = 1'b1;
          i_c    = LW'(pa32);
          if (pb32 < pa32) begin
            dir_c  = 1'b1;
            stop_c = LW'(pb32);
            fin_c  = LW'(pb32);
            from_c = LW'(pb32);
          end else begin
            stop_c = LW'(pb32 - 32'd1);
            fin_c  = LW'(pb32 - 32'd1);
            from_c = LW'(pa32);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign src      = swap_q ? pb_q : (dir_q ? i_q - LW'(1) : i_q + LW'(1));
  assign jm1      = JW'(j_q - LW'(1));
  assign lm1      = JW'(len_q - LW'(1));
  assign cell_sum = 25'(acc_q) + 25'(pt_rdata);
  assign cell_sat = cell_sum[24] ? '1 : cell_sum[23:0];
  assign cell_val = (j_q != '0 && m_q != nm_last && dep_rdata > cell_sat) ?
                    dep_rdata : cell_sat;
  assign flow_add = 33'(flow_q) + 33'(dep_rdata);
  assign flow_sat = flow_add[32] ? '1 : flow_add[31:0];

  // Memory port control.
  always_comb begin
    jo_we     = 1'b0;
    jo_re     = 1'b0;
    jo_waddr  = JW'(i_q);
    jo_raddr  = JW'(j_q);
    jo_wdata  = jo_rdata;
    dep_we    = 1'b0;
    dep_re    = 1'b0;
    dep_waddr = {JW'(j_q), m_q};
    dep_wdata = cell_val;
    dep_raddr = {jm1, MW'(0)};
    pt_we     = 1'b0;
    pt_re     = 1'b0;
    pt_waddr  = {TW'(f_job), MW'(f_mach)};
    pt_raddr  = {TW'(job_r_q), MW'(m_q + MW'(1))};
    case (cmd_i)
      CMD_DECODE: pt_we = ld_c;
      CMD_HOLD_RD: begin
        jo_re    = 1'b1;
        jo_raddr = JW'(pa_q);
      end
      CMD_SH_RD: begin
        jo_re    = 1'b1;
        jo_raddr = JW'(src);
      end
      CMD_SH_WR: jo_we = 1'b1;
      CMD_FIN: begin
        jo_we    = 1'b1;
        jo_waddr = JW'(fin_q);
        jo_wdata = hold_q ? t_q : job_q;
      end
      CMD_ROW_A: begin
        jo_re  = 1'b1;
        dep_re = 1'b1;
      end
      CMD_ROW_B: begin
        pt_re     = 1'b1;
        pt_raddr  = {TW'(jo_rdata), MW'(0)};
        dep_re    = 1'b1;
        dep_raddr = {jm1, MW'(1)};
      end
      CMD_CELL: begin
        dep_we    = 1'b1;
        pt_re     = 1'b1;
        dep_re    = 1'b1;
        dep_raddr = {jm1, MW'(m_q + MW'(2))};
      end
      CMD_SUM: begin
        dep_re    = (k_q < len_q);
        dep_raddr = {JW'(k_q), nm_last};
      end
      CMD_SPAN_RD: begin
        dep_re    = 1'b1;
        dep_raddr = {lm1, nm_last};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (jo_we) begin
      jo_mem[jo_waddr] <= jo_wdata;
    end
    if (jo_re) begin
      jo_rdata <= jo_mem[jo_raddr];
    end
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (dep_re) begin
      dep_rdata <= dep_mem[dep_raddr];
    end
    if (pt_we) begin
      pt_mem[pt_waddr] <= f_tval;
    end
    if (pt_re) begin
      pt_rdata <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      flow_q <= '0;
      edit_q <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_DECODE: begin
          edit_q <= edit_c;
          hold_q <= hold_c;
          if (grow_c) begin
            len_q <= len_q + LW'(1);
          end
        end
        CMD_SUM_INIT: flow_q <= '0;
        CMD_SUM: begin
          if (p_q) begin
            flow_q <= flow_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_DECODE: begin
        st_q   <= st_c;
        job_q  <= f_job;
        pa_q   <= LW'(f_pa);
        pb_q   <= LW'(f_pb);
        i_q    <= i_c;
        stop_q <= stop_c;
        fin_q  <= fin_c;
        dir_q  <= dir_c;
        swap_q <= swap_c;
        j_q    <= from_c;
      end
      CMD_HOLD_LATCH: t_q <= jo_rdata;
      CMD_SH_WR: i_q <= dir_q ? i_q - LW'(1) : i_q + LW'(1);
      CMD_ROW_B: begin
        job_r_q <= jo_rdata;
        acc_q   <= (j_q == '0) ? '0 : dep_rdata;
        m_q     <= '0;
      end
      CMD_CELL: begin
        acc_q <= cell_val;
        m_q   <= m_q + MW'(1);
        if (m_q == nm_last) begin
          j_q <= j_q + LW'(1);
        end
      end
      CMD_SUM_INIT: begin
        k_q <= '0;
        p_q <= 1'b0;
      end
      CMD_SUM: begin
        p_q <= (k_q < len_q);
        if (k_q < len_q) begin
          k_q <= k_q + LW'(1);
        end
      end
      CMD_OUT_LOAD: begin
        out_flow_q <= flow_q;
        out_span_q <= (len_q == '0) ? '0 : dep_rdata;
        out_cnt_q  <= 7'(len_q);
        out_st_q   <= st_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.edit       = edit_q;
  assign status_o.hold       = hold_q;
  assign status_o.shift_more = dir_q ? (i_q > stop_q) : (i_q < stop_q);
  assign status_o.cell_last  = (m_q == nm_last);
  assign status_o.row_last   = (LW'(j_q + LW'(1)) == len_q);
  assign status_o.sum_done   = (k_q == len_q) && !p_q;

  assign out_data_o = {7'd0, out_st_q, out_cnt_q, out_span_q, out_flow_q};

endmodule

// ----- hdl/bfst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop controller
// Sequences decode, job order shifts, row recomputation, flow summation and
// result delivery, and owns both handshakes.
// ----------------------------------------------------------------------------
module bfst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output bfst_pkg::cmd_e        cmd_o,
  input  bfst_pkg::dp_status_t  status_i
);
  import bfst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUTE,
    S_HOLD_RD,
    S_HOLD_LATCH,
    S_SH_RD,
    S_SH_WR,
    S_ROW_A,
    S_ROW_B,
    S_CELL,
    S_SUM_INIT,
    S_SUM,
    S_SPAN_RD,
    S_SPAN_WR
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_load;

  assign out_load  = (state_q == S_SPAN_WR) && (!m_valid_q || m_ready_i);
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      S_IDLE:       cmd_o = s_valid_i ? CMD_DECODE : CMD_NONE;
      S_HOLD_RD:    cmd_o = CMD_HOLD_RD;
      S_HOLD_LATCH: cmd_o = CMD_HOLD_LATCH;
      S_SH_RD:      cmd_o = status_i.shift_more ? CMD_SH_RD : CMD_FIN;
      S_SH_WR:      cmd_o = CMD_SH_WR;
      S_ROW_A:      cmd_o = CMD_ROW_A;
      S_ROW_B:      cmd_o = CMD_ROW_B;
      S_CELL:       cmd_o = CMD_CELL;
      S_SUM_INIT:   cmd_o = CMD_SUM_INIT;
      S_SUM:        cmd_o = CMD_SUM;
      S_SPAN_RD:    cmd_o = CMD_SPAN_RD;
      S_SPAN_WR:    cmd_o = out_load ? CMD_OUT_LOAD : CMD_NONE;
      default:      cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            state_q <= S_ROUTE;
          end
        end
        S_ROUTE: begin
          if (!status_i.edit) begin
            state_q <= S_SPAN_RD;
          end else if (status_i.hold) begin
            state_q <= S_HOLD_RD;
          end else begin
            state_q <= S_SH_RD;
          end
        end
        S_HOLD_RD:    state_q <= S_HOLD_LATCH;
        S_HOLD_LATCH: state_q <= S_SH_RD;
        S_SH_RD:      state_q <= status_i.shift_more ? S_SH_WR : S_ROW_A;
        S_SH_WR:      state_q <= S_SH_RD;
        S_ROW_A:      state_q <= S_ROW_B;
        S_ROW_B:      state_q <= S_CELL;
        S_CELL: begin
          if (status_i.cell_last) begin
            state_q <= status_i.row_last ? S_SUM_INIT : S_ROW_A;
          end
        end
        S_SUM_INIT:   state_q <= S_SUM;
        S_SUM: begin
          if (status_i.sum_done) begin
            state_q <= S_SPAN_RD;
          end
        end
        S_SPAN_RD:    state_q <= S_SPAN_WR;
        S_SPAN_WR: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default:      state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/blocking_flowshop_schedule_table.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop schedule table
// One input beat in, one result beat out per item; times load, the job
// sequence is edited and the departure table is recomputed from the first
// changed row, then the flow time is summed.
// ----------------------------------------------------------------------------
// Loads, rejected items and no-op moves go from decode through the route,
// span-read and span-write states to the result. An edit reads and writes
// each shifted sequence entry, reads the job and the previous row for each
// recomputed row and then computes one cell per machine, and reads the last
// departure of every row for the flow sum. One item is in flight at a time.
// Reset clears the length, the flow sum and the register (16 machines); the
// memories are not cleared and need no clearing pass.
module blocking_flowshop_schedule_table #(
  parameter int unsigned MAX_JOBS     = bfst_pkg::MaxJobsDef,
  parameter int unsigned MAX_MACHINES = bfst_pkg::MaxMachinesDef,
  parameter int unsigned JOB_TYPES    = bfst_pkg::JobTypesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // job, machine, time_value, pos_a, pos_b
  input  logic [bfst_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode
  input  logic [bfst_pkg::ModeW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // total_flow_time, makespan, job_count, status
  output logic [bfst_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bfst_pkg::*;

  logic [CfgW-1:0] machines_q;
  cmd_e            cmd;
  dp_status_t      dp_status;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(machines_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machines_q <= MachinesReset;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      machines_q <= pwdata[CfgW-1:0];
    end
  end

  bfst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .status_i  (dp_status)
  );

  bfst_dpath #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES),
    .JOB_TYPES    (JOB_TYPES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .in_data_i  (s_axis_tdata_i),
    .in_mode_i  (s_axis_tuser_i),
    .machines_i (machines_q),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ----- dv/blocking_flowshop_schedule_table_chk.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop schedule table checker
// Watches the input, result and register ports, keeps its own copy of the
// job sequence, time table and departure table, predicts every result beat
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module blocking_flowshop_schedule_table_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [bfst_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [bfst_pkg::ModeW-1:0]    s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [bfst_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output int                            errors_o,
  output int                            pending_o
);
  import bfst_pkg::*;

  typedef struct packed {
    logic [31:0] flow;
    logic [23:0] span;
    logic [6:0]  count;
    logic [1:0]  status;
  } sched_result_t;

  logic [4:0]  machines_reg;
  logic [7:0]  seq_jobs [64];
  logic [23:0] depart [64][16];
  logic [9:0]  ptime [256][16];
  int          seq_len;
  logic [31:0] flow_total;
  sched_result_t results_due[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = results_due.size();

  function automatic int line_width();
    if (machines_reg < 2) return 2;
    if (machines_reg > 16) return 16;
    return int'(machines_reg);
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] a, logic [9:0] b);
    logic [24:0] s;
    s = 25'(a) + 25'(b);
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic logic [23:0] larger(logic [23:0] a, logic [23:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic void refresh_rows(int from);
    int         nm;
    logic [7:0] jt;
    longint     sum;
    nm  = line_width();
    sum = 0;
    for (int j = from; j < seq_len; j++) begin
      jt = seq_jobs[j];
      if (j == 0) begin
        depart[0][0] = 24'(ptime[jt][0]);
        for (int m = 1; m < nm; m++) depart[0][m] = sat_add(depart[0][m-1], ptime[jt][m]);
      end else begin
        depart[j][0] = larger(sat_add(depart[j-1][0], ptime[jt][0]), depart[j-1][1]);
        for (int m = 1; m + 1 < nm; m++)
          depart[j][m] = larger(sat_add(depart[j][m-1], ptime[jt][m]), depart[j-1][m+1]);
        depart[j][nm-1] = sat_add(depart[j][nm-2], ptime[jt][nm-1]);
      end
    end
    for (int j = 0; j < seq_len; j++) sum += longint'(depart[j][nm-1]);
    flow_total = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
  endfunction

  function automatic sched_result_t apply_command(logic [2:0] mode, logic [39:0] d);
    logic [7:0]    job;
    logic [3:0]    mach;
    logic [9:0]    tval;
    int            pa, pb, pos;
    logic [7:0]    held;
    sched_result_t r;
    job  = d[7:0];
    mach = d[11:8];
    tval = d[21:12];
    pa   = int'(d[27:22]);
    pb   = int'(d[34:28]);
    r.status = StOk;
    case (mode)
      ModeLoad: ptime[job][mach] = tval;
      ModeAppend, ModeInsert: begin
        pos = (mode == ModeAppend) ? seq_len : pb;
        if (seq_len >= 64) begin
          r.status = StFull;
        end else if (pos > seq_len) begin
          r.status = StRange;
        end else begin
          for (int i = seq_len; i > pos; i--) seq_jobs[i] = seq_jobs[i-1];
          seq_jobs[pos] = job;
          seq_len++;
          refresh_rows(pos);
        end
      end
      ModeSwap: begin
        if (pa >= seq_len || pb >= seq_len) begin
          r.status = StRange;
        end else begin
          held = seq_jobs[pa];
          seq_jobs[pa] = seq_jobs[pb];
          seq_jobs[pb] = held;
          refresh_rows(pa < pb ? pa : pb);
        end
      end
      ModeMove: begin
        if (pa >= seq_len || pb > seq_len) begin
          r.status = StRange;
        end else if (pb != pa && pb != pa + 1) begin
          held = seq_jobs[pa];
          if (pb < pa) begin
            for (int i = pa; i > pb; i--) seq_jobs[i] = seq_jobs[i-1];
            seq_jobs[pb] = held;
            refresh_rows(pb);
          end else begin
            for (int i = pa; i + 1 < pb; i++) seq_jobs[i] = seq_jobs[i+1];
            seq_jobs[pb-1] = held;
            refresh_rows(pa);
          end
        end
      end
      default: ;
    endcase
    r.flow  = flow_total;
    r.span  = (seq_len > 0) ? depart[seq_len-1][line_width()-1] : 24'd0;
    r.count = 7'(seq_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t got, want;
    if (!rst_ni) begin
      machines_reg = MachinesReset;
      seq_len      = 0;
      flow_total   = '0;
      errors       = 0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) machines_reg = pwdata[4:0];
      if (s_axis_tvalid_i && s_axis_tready_i)
        results_due = {results_due, apply_command(s_axis_tuser_i, s_axis_tdata_i)};
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.flow   = m_axis_tdata_i[31:0];
        got.span   = m_axis_tdata_i[55:32];
        got.count  = m_axis_tdata_i[62:56];
        got.status = m_axis_tdata_i[64:63];
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata_i);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.flow != want.flow) begin
            $error("total_flow_time: expected %0d, got %0d", want.flow, got.flow);
            errors++;
          end
          if (got.span != want.span) begin
            $error("makespan: expected %0d, got %0d", want.span, got.span);
            errors++;
          end
          if (got.count != want.count) begin
            $error("job_count: expected %0d, got %0d", want.count, got.count);
            errors++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- dv/blocking_flowshop_schedule_table_tb.sv -----
// ----------------------------------------------------------------------------
// Blocking flowshop schedule table testbench
// Loads processing times, builds and reorders job sequences under several
// machine counts with random gaps on both streams, and leaves prediction and
// comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module blocking_flowshop_schedule_table_tb;
  import bfst_pkg::*;

  localparam int unsigned QuietLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [ModeW-1:0]    s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int          mismatches, outstanding;
  int          beats_in, beats_out, quiet_cycles;
  int          gap_pct = 6;
  int          seq_count;
  logic [15:0] loaded [256];
  logic [7:0]  ready_jobs[$];
  int          fill_job = -1;
  int          fill_mach;

  blocking_flowshop_schedule_table dut (.*);

  blocking_flowshop_schedule_table_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o), .psel, .penable, .pwrite,
    .pready, .paddr, .pwdata, .errors_o(mismatches), .pending_o(outstanding)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(0, 99) >= gap_pct);
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) beats_in++;
    if (m_axis_tvalid_o && m_axis_tready_i) beats_out++;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [2:0] mode, logic [7:0] job, logic [3:0] mach,
                           logic [9:0] tval, logic [5:0] pa, logic [6:0] pb);
    while ($urandom_range(0, 99) < gap_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = mode;
    s_axis_tdata_i  = {5'b0, pb, pa, tval, mach, job};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    case (mode)
      ModeLoad: begin
        if (loaded[job] != 16'hFFFF && (loaded[job] | (16'd1 << mach)) == 16'hFFFF)
          ready_jobs = {ready_jobs, job};
        loaded[job][mach] = 1'b1;
      end
      ModeAppend: if (seq_count < 64) seq_count++;
      ModeInsert: if (seq_count < 64 && pb <= seq_count) seq_count++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (beats_out != beats_in) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_machines(logic [4:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = 3'd0;
    pwdata  = {$urandom} & 32'hFFFFFFE0 | 32'(value);
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_beat();
    int         r;
    logic [2:0] mode;
    logic [7:0] job;
    logic [3:0] mach;
    logic [9:0] tval;
    logic [5:0] pa;
    logic [6:0] pb;
    r    = $urandom_range(0, 99);
    job  = 8'($urandom);
    mach = 4'($urandom);
    tval = 10'($urandom);
    pa   = 6'($urandom);
    pb   = 7'($urandom);
    if (r < 30 || ready_jobs.size() == 0) begin
      mode = ModeLoad;
      if ($urandom_range(0, 9) < 7) begin
        if (fill_job < 0) begin
          fill_job  = $urandom_range(0, 255);
          fill_mach = 0;
        end
        job  = 8'(fill_job);
        mach = 4'(fill_mach);
        fill_mach++;
        if (fill_mach == 16) fill_job = -1;
      end
      if ($urandom_range(0, 9) == 0) tval = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
    end else begin
      job = ready_jobs[$urandom_range(0, ready_jobs.size() - 1)];
      if (r < 50) begin
        mode = ModeAppend;
      end else if (r < 62) begin
        mode = ModeInsert;
        if ($urandom_range(0, 9) != 0) pb = 7'($urandom_range(0, seq_count));
      end else if (r < 75) begin
        mode = ModeSwap;
        if (seq_count > 0 && $urandom_range(0, 9) != 0) begin
          pa = 6'($urandom_range(0, seq_count - 1));
          pb = 7'($urandom_range(0, seq_count - 1));
        end
      end else if (r < 94) begin
        mode = ModeMove;
        if (seq_count > 0 && $urandom_range(0, 9) != 0) begin
          pa = 6'($urandom_range(0, seq_count - 1));
          pb = 7'($urandom_range(0, seq_count));
        end
      end else begin
        mode = 3'($urandom_range(5, 7));
      end
    end
    send_beat(mode, job, mach, tval, pa, pb);
  endtask

  initial begin
    logic [4:0] settings [6] = '{5'd16, 5'd2, 5'd9, 5'd0, 5'd31, 5'd5};
    foreach (loaded[j]) loaded[j] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int m = 0; m < 16; m++) begin
      send_beat(ModeLoad, 8'd0, 4'(m), 10'd0, 6'd0, 7'd0);
      send_beat(ModeLoad, 8'd255, 4'(m), 10'h3FF, 6'd63, 7'd127);
    end
    send_beat(ModeSwap, 8'd0, 4'd0, 10'd0, 6'd0, 7'd0);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd0, 7'd0);
    send_beat(ModeInsert, 8'd255, 4'd0, 10'd0, 6'd0, 7'd1);
    send_beat(ModeAppend, 8'd255, 4'd15, 10'h3FF, 6'd63, 7'd127);
    send_beat(ModeInsert, 8'd0, 4'd0, 10'd0, 6'd0, 7'd0);
    send_beat(ModeAppend, 8'd255, 4'd0, 10'd0, 6'd0, 7'd0);
    send_beat(ModeSwap, 8'd0, 4'd0, 10'd0, 6'd0, 7'd2);
    send_beat(ModeSwap, 8'd0, 4'd0, 10'd0, 6'd1, 7'd1);
    send_beat(ModeSwap, 8'd0, 4'd0, 10'd0, 6'd0, 7'd3);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd1, 7'd2);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd2, 7'd0);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd0, 7'd3);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd3, 7'd1);
    send_beat(ModeMove, 8'd0, 4'd0, 10'd0, 6'd0, 7'd4);
    send_beat(3'd7, 8'd255, 4'd15, 10'h3FF, 6'd63, 7'd127);

    foreach (settings[p]) begin
      wait_drained();
      write_machines(settings[p]);
      if (seq_count > 0) send_beat(ModeSwap, 8'd0, 4'd0, 10'd0, 6'd0, 7'd0);
      gap_pct = (p == 2) ? 0 : 6;
      for (int n = 0; n < 85; n++) begin
        if (p == 1 && n == 40) wait_drained();
        random_beat();
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bfst_pkg.sv
hdl/bfst_dpath.sv
hdl/bfst_ctrl.sv
hdl/blocking_flowshop_schedule_table.sv
dv/blocking_flowshop_schedule_table_chk.sv
dv/blocking_flowshop_schedule_table_tb.sv
